// ===== rtl/cppt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cppt_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned INTERVAL_W = 10;
    localparam int unsigned QUOT_W     = 34;
    localparam int unsigned IDX_W      = 6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd10;
    localparam logic [QUOT_W-1:0]     QUOT_CAP       = 34'h2_0000_0000;
    localparam logic [29:0]           ANGLE_PER_RAD  = 30'd683565276;
    localparam logic [DATA_W-1:0]     HALF_TURN      = 32'h8000_0000;

    localparam logic [31:0] ATAN_TABLE [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DECIDE    = 13'b0000000000010,
        S_MAC       = 13'b0000000000100,
        S_DIVA_INIT = 13'b0000000001000,
        S_DIVA      = 13'b0000000010000,
        S_SCALE     = 13'b0000000100000,
        S_DIVB_INIT = 13'b0000001000000,
        S_DIVB      = 13'b0000010000000,
        S_LIN_FIN   = 13'b0000100000000,
        S_SQ        = 13'b0001000000000,
        S_ROOT      = 13'b0010000000000,
        S_EXACT_FIN = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             load_commit;
        logic             mac_step;
        logic             diva_start;
        logic             diva_step;
        logic             scale;
        logic             divb_start;
        logic             divb_step;
        logic             lin_commit;
        logic             sq_step;
        logic             root_step;
        logic             exact_commit;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic take_exact;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/cppt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cppt_div (
    input  wire logic        clk,
    input  wire logic        start,
    input  wire logic        step,
    input  wire logic [31:0] init_rem,
    input  wire logic [63:0] init_num,
    input  wire logic [31:0] divisor,
    output logic      [63:0] quot
);

    logic [31:0] rem_reg;
    logic [63:0] num_reg;
    logic [63:0] quot_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, num_reg[63]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});
    assign quot  = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= init_rem;
            num_reg  <= init_num;
            quot_reg <= '0;
        end
        else if (step)
        begin
            rem_reg  <= ge ? diff[31:0] : trial[31:0];
            num_reg  <= {num_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cppt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cppt_datapath #(
    parameter int POSITION_WIDTH    = 32,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cppt_pkg::cmd_t       cmd,
    output cppt_pkg::status_t         status,
    input  wire logic                 cfg_write,
    input  wire logic [9:0]           cfg_data,
    input  wire logic                 operation,
    input  wire logic signed [31:0]   value_x,
    input  wire logic signed [31:0]   value_y,
    input  wire logic [31:0]          start_radius,
    input  wire logic signed [31:0]   start_angle,
    output logic signed [31:0]        pos_x,
    output logic signed [31:0]        pos_y,
    output logic [31:0]               radius,
    output logic signed [31:0]        angle,
    output logic                      corrected
);

    import cppt_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int AW = POSITION_WIDTH + 33;
    localparam int CW = POSITION_WIDTH + 3;

    logic                    in_op_reg;
    logic signed [31:0]      in_x_reg;
    logic signed [31:0]      in_y_reg;
    logic [31:0]             in_r_reg;
    logic [31:0]             in_a_reg;

    logic signed [PW-1:0]    cur_x_reg;
    logic signed [PW-1:0]    cur_y_reg;
    logic [31:0]             cur_r_reg;
    logic [31:0]             cur_a_reg;
    logic [9:0]              step_cnt_reg;
    logic [9:0]              interval_reg;
    logic                    corr_reg;

    logic signed [PW-1:0]    nx;
    logic signed [PW-1:0]    ny;
    logic [9:0]              cnt_inc;

    logic signed [AW-1:0]    x_a;
    logic signed [AW-1:0]    y_a;
    logic signed [AW-1:0]    dterm;
    logic signed [AW-1:0]    cterm;
    logic signed [AW-1:0]    dot_base;
    logic signed [AW-1:0]    cross_base;
    logic signed [AW-1:0]    dot_reg;
    logic signed [AW-1:0]    cross_reg;
    logic                    mac_first;
    logic                    bx;
    logic                    by;

    logic [AW-1:0]           mag_dot;
    logic [AW-1:0]           mag_cr;
    logic [AW-1:0]           hi_dot;
    logic [AW-1:0]           hi_cr;
    logic                    neg_r_reg;
    logic                    neg_a_reg;
    logic                    over_r_reg;
    logic                    over_a_reg;
    logic [63:0]             quot_a;
    logic [63:0]             quot_b;
    logic [QUOT_W-1:0]       qa;
    logic [QUOT_W-1:0]       qb;
    logic [QUOT_W-1:0]       drm_reg;
    logic [QUOT_W-1:0]       tm_reg;
    logic [63:0]             prod;
    logic                    start_b;
    logic [31:0]             init_rem_b;
    logic [63:0]             init_num_b;

    logic signed [35:0]      nr;
    logic [31:0]             nr_sat;
    logic [31:0]             am;
    logic [31:0]             delta_a;

    logic [PW-1:0]           mag_nx;
    logic [PW-1:0]           mag_ny;
    logic [63:0]             m64x;
    logic [63:0]             m64y;
    logic                    over_xy;
    logic [31:0]             sq_op;
    logic [63:0]             sq_prod;
    logic [64:0]             sq_sum_reg;
    logic                    over_xy_reg;
    logic                    sat_reg;

    logic                    root_first;
    logic [33:0]             rem_base;
    logic [31:0]             root_base;
    logic [35:0]             rem_wide;
    logic [35:0]             trial_wide;
    logic [35:0]             rem_diff;
    logic                    root_ge;
    logic [33:0]             rem_reg;
    logic [31:0]             root_reg;

    logic signed [CW-1:0]    px_reg;
    logic signed [CW-1:0]    py_reg;
    logic signed [CW-1:0]    px_init;
    logic signed [CW-1:0]    py_init;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic [31:0]             z_reg;
    logic                    zero_reg;
    logic [4:0]              ci;
    logic                    py_pos;

    assign nx      = cur_x_reg + PW'(in_x_reg);
    assign ny      = cur_y_reg + PW'(in_y_reg);
    assign cnt_inc = step_cnt_reg + 10'd1;

    assign status.is_load    = (in_op_reg == OP_LOAD);
    assign status.take_exact = ((interval_reg != '0) && (cnt_inc == interval_reg))
                               || (cur_r_reg == '0);

    // Multiplier bits are taken MSB first; bit 31 of the step carries negative weight.
    assign x_a       = AW'(cur_x_reg);
    assign y_a       = AW'(cur_y_reg);
    assign bx        = in_x_reg[cmd.idx[4:0]];
    assign by        = in_y_reg[cmd.idx[4:0]];
    assign mac_first = (cmd.idx[4:0] == 5'd31);
    assign dterm     = (bx ? x_a : AW'(0)) + (by ? y_a : AW'(0));
    assign cterm     = (by ? x_a : AW'(0)) - (bx ? y_a : AW'(0));
    assign dot_base   = mac_first ? AW'(0) : (dot_reg <<< 1);
    assign cross_base = mac_first ? AW'(0) : (cross_reg <<< 1);

    assign mag_dot = dot_reg[AW-1] ? AW'(-dot_reg) : AW'(dot_reg);
    assign mag_cr  = cross_reg[AW-1] ? AW'(-cross_reg) : AW'(cross_reg);
    assign hi_dot  = mag_dot >> QUOT_W;
    assign hi_cr   = mag_cr >> QUOT_W;

    assign qa   = quot_a[QUOT_W-1:0];
    assign qb   = quot_b[QUOT_W-1:0];
    assign prod = tm_reg * ANGLE_PER_RAD;

    assign start_b    = cmd.diva_start | cmd.divb_start;
    assign init_rem_b = cmd.divb_start ? 32'd0 : hi_cr[31:0];
    assign init_num_b = cmd.divb_start ? prod : {mag_cr[QUOT_W-1:0], 30'd0};

    cppt_div u_div_a (
        .clk      (clk),
        .start    (cmd.diva_start),
        .step     (cmd.diva_step),
        .init_rem (hi_dot[31:0]),
        .init_num ({mag_dot[QUOT_W-1:0], 30'd0}),
        .divisor  (cur_r_reg),
        .quot     (quot_a)
    );

    cppt_div u_div_b (
        .clk      (clk),
        .start    (start_b),
        .step     (cmd.diva_step | cmd.divb_step),
        .init_rem (init_rem_b),
        .init_num (init_num_b),
        .divisor  (cur_r_reg),
        .quot     (quot_b)
    );

    assign nr = neg_r_reg ? ($signed({4'b0, cur_r_reg}) - $signed({2'b0, drm_reg}))
                          : ($signed({4'b0, cur_r_reg}) + $signed({2'b0, drm_reg}));
    always_comb
    begin
        if (nr[35])
            nr_sat = '0;
        else if (nr[35:32] != '0)
            nr_sat = '1;
        else
            nr_sat = nr[31:0];
    end
    assign am      = quot_b[31:0];
    assign delta_a = neg_a_reg ? (32'd0 - am) : am;

    assign mag_nx  = nx[PW-1] ? PW'(-nx) : PW'(nx);
    assign mag_ny  = ny[PW-1] ? PW'(-ny) : PW'(ny);
    assign m64x    = 64'(mag_nx);
    assign m64y    = 64'(mag_ny);
    assign over_xy = (m64x[63:32] != '0) || (m64y[63:32] != '0);
    assign sq_op   = cmd.idx[0] ? m64x[31:0] : m64y[31:0];
    assign sq_prod = sq_op * sq_op;

    assign root_first = (cmd.idx[4:0] == 5'd31);
    assign rem_base   = root_first ? 34'd0 : rem_reg;
    assign root_base  = root_first ? 32'd0 : root_reg;
    assign rem_wide   = {rem_base, sq_sum_reg[63:62]};
    assign trial_wide = 36'({root_base, 2'b01});
    assign rem_diff   = rem_wide - trial_wide;
    assign root_ge    = (rem_wide >= trial_wide);

    assign px_init = nx[PW-1] ? -CW'(nx) : CW'(nx);
    assign py_init = nx[PW-1] ? -CW'(ny) : CW'(ny);
    assign ci      = ~cmd.idx[4:0];
    assign xs      = px_reg >>> ci;
    assign ys      = py_reg >>> ci;
    assign py_pos  = !py_reg[CW-1] && (py_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            cur_r_reg    <= '0;
            cur_a_reg    <= '0;
            step_cnt_reg <= '0;
            interval_reg <= INTERVAL_RESET;
            corr_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                interval_reg <= cfg_data;
            if (cmd.load_commit)
            begin
                cur_x_reg    <= PW'(in_x_reg);
                cur_y_reg    <= PW'(in_y_reg);
                cur_r_reg    <= in_r_reg;
                cur_a_reg    <= in_a_reg;
                step_cnt_reg <= '0;
                corr_reg     <= 1'b0;
            end
            else if (cmd.lin_commit)
            begin
                cur_x_reg    <= nx;
                cur_y_reg    <= ny;
                cur_r_reg    <= nr_sat;
                cur_a_reg    <= cur_a_reg + delta_a;
                step_cnt_reg <= cnt_inc;
                corr_reg     <= 1'b0;
            end
            else if (cmd.exact_commit)
            begin
                cur_x_reg    <= nx;
                cur_y_reg    <= ny;
                cur_r_reg    <= sat_reg ? 32'hFFFF_FFFF : root_reg;
                cur_a_reg    <= zero_reg ? 32'd0 : z_reg;
                step_cnt_reg <= '0;
                corr_reg     <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_op_reg <= operation;
            in_x_reg  <= value_x;
            in_y_reg  <= value_y;
            in_r_reg  <= start_radius;
            in_a_reg  <= start_angle;
        end

        if (cmd.mac_step)
        begin
            dot_reg   <= mac_first ? (dot_base - dterm) : (dot_base + dterm);
            cross_reg <= mac_first ? (cross_base - cterm) : (cross_base + cterm);
        end

        if (cmd.diva_start)
        begin
            neg_r_reg  <= dot_reg[AW-1];
            neg_a_reg  <= cross_reg[AW-1];
            over_r_reg <= (hi_dot >= AW'(cur_r_reg));
            over_a_reg <= (hi_cr >= AW'(cur_r_reg));
        end

        if (cmd.scale)
        begin
            drm_reg <= (over_r_reg || (qa > QUOT_CAP)) ? QUOT_CAP : qa;
            tm_reg  <= (over_a_reg || (qb > QUOT_CAP)) ? QUOT_CAP : qb;
        end

        if (cmd.sq_step)
        begin
            if (cmd.idx[0])
            begin
                sq_sum_reg  <= {1'b0, sq_prod};
                over_xy_reg <= over_xy;
                px_reg      <= px_init;
                py_reg      <= py_init;
                z_reg       <= nx[PW-1] ? HALF_TURN : 32'd0;
                zero_reg    <= (nx == '0) && (ny == '0);
            end
            else
            begin
                sq_sum_reg <= sq_sum_reg + {1'b0, sq_prod};
            end
        end

        if (cmd.root_step)
        begin
            if (root_first)
                sat_reg <= over_xy_reg || sq_sum_reg[64];
            sq_sum_reg <= {sq_sum_reg[62:0], 2'b00};
            rem_reg    <= root_ge ? rem_diff[33:0] : rem_wide[33:0];
            root_reg   <= {root_base[30:0], root_ge};
            if (int'(ci) < CORDIC_ITERATIONS)
            begin
                if (py_pos)
                begin
                    px_reg <= px_reg + ys;
                    py_reg <= py_reg - xs;
                    z_reg  <= z_reg + ATAN_TABLE[ci];
                end
                else
                begin
                    px_reg <= px_reg - ys;
                    py_reg <= py_reg + xs;
                    z_reg  <= z_reg - ATAN_TABLE[ci];
                end
            end
        end

        if (cmd.emit)
        begin
            pos_x     <= 32'(cur_x_reg);
            pos_y     <= 32'(cur_y_reg);
            radius    <= cur_r_reg;
            angle     <= cur_a_reg;
            corrected <= corr_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cppt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cppt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cppt_pkg::status_t status,
    output cppt_pkg::cmd_t         cmd
);

    import cppt_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.idx        = cnt_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.is_load)
                begin
                    cmd.load_commit = 1'b1;
                    state_next      = S_EMIT;
                end
                else if (status.take_exact)
                begin
                    cnt_next   = 6'd1;
                    state_next = S_SQ;
                end
                else
                begin
                    cnt_next   = 6'd31;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = S_DIVA_INIT;
            end
            S_DIVA_INIT:
            begin
                cmd.diva_start = 1'b1;
                cnt_next       = 6'(QUOT_W - 1);
                state_next     = S_DIVA;
            end
            S_DIVA:
            begin
                cmd.diva_step = 1'b1;
                cnt_next      = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_DIVB_INIT;
            end
            S_DIVB_INIT:
            begin
                cmd.divb_start = 1'b1;
                cnt_next       = 6'd63;
                state_next     = S_DIVB;
            end
            S_DIVB:
            begin
                cmd.divb_step = 1'b1;
                cnt_next      = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = S_LIN_FIN;
            end
            S_LIN_FIN:
            begin
                cmd.lin_commit = 1'b1;
                state_next     = S_EMIT;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = 6'd31;
                    state_next = S_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = S_EXACT_FIN;
            end
            S_EXACT_FIN:
            begin
                cmd.exact_commit = 1'b1;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/correcting_polar_position_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Signals                                              Accepted when
// input    operation value_x value_y start_radius start_angle   in_valid and in_ready
// output   pos_x pos_y radius angle corrected                   out_valid and out_ready
// config   cfg_data (correction interval)                       cfg_valid and cfg_ready
//
// A linear update runs the bit-serial multiply-accumulate and the two restoring
// dividers (34 and 64 steps) that work one bit per cycle.
// Reset clears the position, the polar state and the step count and sets the
// interval to 10. A finished word waits in the output register while the next
// input word is taken; the result after that waits until the output is free.

module correcting_polar_position_tracker #(
    parameter int POSITION_WIDTH    = 32,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic signed [31:0] value_x,
    input  wire logic signed [31:0] value_y,
    input  wire logic [31:0]        start_radius,
    input  wire logic signed [31:0] start_angle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic [31:0]             radius,
    output logic signed [31:0]      angle,
    output logic                    corrected,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [9:0]         cfg_data
);

    import cppt_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cppt_datapath #(
        .POSITION_WIDTH    (POSITION_WIDTH),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .value_x      (value_x),
        .value_y      (value_y),
        .start_radius (start_radius),
        .start_angle  (start_angle),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .radius       (radius),
        .angle        (angle),
        .corrected    (corrected)
    );

    a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_commit, cmd.lin_commit, cmd.exact_commit, cmd.emit}))
        else $error("more than one state update in a cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result word overwritten before it was taken");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again while a word is in work");

endmodule

`default_nettype wire
